@@ src/gbia_pkg.sv @@
// gbia_pkg: shared types and constants of the growable bitmap id allocator
// no dependencies; used by the controller, datapath and top level

package gbia_pkg;

  // fixed field widths
  localparam int ID_W      = 10;
  localparam int ST_W      = 2;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  // request operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_ALLOC   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_FREED   = 2'd2;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CAP  = 1'b1;

  // register values after reset
  localparam logic [CFG_W-1:0] INIT_CAP_RESET = 11'd32;
  localparam logic [CFG_W-1:0] MAX_CAP_RESET  = 11'd0;

  // request payload
  typedef struct packed {
    logic            operation;
    logic [ID_W-1:0] id;
  } req_t;

  // result payload
  typedef struct packed {
    logic [ID_W-1:0]  result_id;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] used_now;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;
    logic find;
    logic read;
    logic commit;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } ctl_sts_t;

endpackage

@@ src/gbia_stream_if.sv @@
// gbia_stream_if: valid/ready channel carrying one payload per transfer
// payload type is a parameter; depends on nothing else

interface gbia_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/gbia_ctrl.sv @@
// gbia_ctrl: sequencing state machine of the id allocator
// depends on gbia_pkg for the command and status structs

module gbia_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output gbia_pkg::ctl_cmd_t cmd,
  input  gbia_pkg::ctl_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_MOD  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands to the datapath
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.take   = (state_r == S_IDLE) && in_valid;
  assign cmd.find   = (state_r == S_ADDR);
  assign cmd.read   = (state_r == S_READ);
  assign cmd.commit = (state_r == S_MOD) && sts.out_free;

endmodule

@@ src/gbia_datapath.sv @@
// gbia_datapath: bitmap store, word flags, capacity and count of the id allocator
// depends on gbia_pkg; driven by gbia_ctrl commands

module gbia_datapath #(
  parameter int MAX_IDS   = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gbia_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbia_pkg::CFG_W-1:0]      cfg_data,
  input  gbia_pkg::req_t                  in_data,
  output gbia_pkg::rsp_t                  out_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  gbia_pkg::ctl_cmd_t              cmd,
  output gbia_pkg::ctl_sts_t              sts
);

  localparam int WB_LOG = $clog2(WORD_BITS);
  localparam int NW     = MAX_IDS / WORD_BITS;
  localparam int AD     = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW     = $clog2(MAX_IDS + 1);
  localparam int AW     = ((CW > gbia_pkg::CFG_W) ? CW : gbia_pkg::CFG_W) + 1;

  // round a requested capacity up to whole words, at least one, at most the store
  function automatic logic [CW-1:0] round_cap(input logic [gbia_pkg::CFG_W-1:0] v);
    logic [AW-1:0] c;
    logic [AW-1:0] up;
    c  = (v == '0) ? AW'(1) : AW'(v);
    up = ((c + AW'(WORD_BITS - 1)) >> WB_LOG) << WB_LOG;
    if (up > AW'(MAX_IDS)) begin
      up = AW'(MAX_IDS);
    end
    return up[CW-1:0];
  endfunction

  logic [gbia_pkg::CFG_W-1:0] max_cap_r;
  logic [CW-1:0]              cap_r;
  logic [CW-1:0]              used_r;
  logic                       op_r;
  logic [gbia_pkg::ID_W-1:0]  id_r;
  logic [AD-1:0]              addr_r;
  logic                       hit_r;
  logic [NW-1:0]              word_vld_r;
  logic [NW-1:0]              word_full_r;
  logic [WORD_BITS-1:0]       mem [NW];
  logic [WORD_BITS-1:0]       rd_data_r;
  logic                       rd_vld_r;
  gbia_pkg::rsp_t             out_r;
  logic                       out_valid_r;

  // word search
  logic          any_elig;
  logic [AD-1:0] first_w;
  logic [AD-1:0] cap_word;
  logic [AD-1:0] id_word;

  // modify stage
  logic [WORD_BITS-1:0] word;
  logic                 any_clr;
  logic [WB_LOG-1:0]    lc;
  logic [AW-1:0]        lc_id;
  logic [AW-1:0]        cap_ext;
  logic [AW-1:0]        max_ext;
  logic [AW-1:0]        grow_cap;
  logic                 alloc_ok;
  logic                 grow_ok;
  logic                 free_ok;
  logic [WB_LOG-1:0]    id_bit;
  logic                 wr;
  logic [WORD_BITS-1:0] word_nxt;
  logic [AW-1:0]        rid;
  logic [gbia_pkg::ST_W-1:0] st;
  logic [CW-1:0]        used_nxt;
  logic [CW-1:0]        cap_nxt;

  // first word that still has room below the capacity
  always_comb begin
    any_elig = 1'b0;
    first_w  = '0;
    for (int w = NW - 1; w >= 0; w--) begin
      if (((AW'(w) << WB_LOG) < AW'(cap_r)) && !word_full_r[w]) begin
        any_elig = 1'b1;
        first_w  = AD'(w);
      end
    end
  end

  assign cap_word = AD'(cap_r >> WB_LOG);
  assign id_word  = AD'(id_r >> WB_LOG);

  // word as stored; never written words read as zero
  assign word = rd_vld_r ? rd_data_r : '0;

  // lowest clear bit of the word
  always_comb begin
    any_clr = 1'b0;
    lc      = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b]) begin
        any_clr = 1'b1;
        lc      = WB_LOG'(b);
      end
    end
  end

  assign lc_id   = (AW'(addr_r) << WB_LOG) | AW'(lc);
  assign cap_ext = AW'(cap_r);
  assign max_ext = AW'(max_cap_r);
  assign id_bit  = id_r[WB_LOG-1:0];

  // doubled capacity, limited by the maximum and by the store
  always_comb begin
    grow_cap = cap_ext << 1;
    if ((max_ext != '0) && (grow_cap > max_ext)) begin
      grow_cap = max_ext;
    end
    if (grow_cap > AW'(MAX_IDS)) begin
      grow_cap = AW'(MAX_IDS);
    end
  end

  assign alloc_ok = hit_r && any_clr && (lc_id < cap_ext);
  assign grow_ok  = ((max_ext == '0) || (cap_ext < max_ext)) && (grow_cap > cap_ext);
  assign free_ok  = (AW'(id_r) < cap_ext) && word[id_bit];

  // result and store update
  always_comb begin
    wr       = 1'b0;
    word_nxt = word;
    rid      = '0;
    st       = gbia_pkg::ST_FULL;
    used_nxt = used_r;
    cap_nxt  = cap_r;
    if (op_r == gbia_pkg::OP_ALLOC) begin
      if (alloc_ok) begin
        wr       = 1'b1;
        word_nxt = word | (WORD_BITS'(1) << lc);
        rid      = lc_id;
        st       = gbia_pkg::ST_ALLOC;
        used_nxt = used_r + CW'(1);
      end else if (grow_ok) begin
        wr       = 1'b1;
        word_nxt = word | (WORD_BITS'(1) << cap_r[WB_LOG-1:0]);
        rid      = cap_ext;
        st       = gbia_pkg::ST_ALLOC;
        used_nxt = used_r + CW'(1);
        cap_nxt  = grow_cap[CW-1:0];
      end
    end else begin
      rid = AW'(id_r);
      if (free_ok) begin
        wr       = 1'b1;
        word_nxt = word & ~(WORD_BITS'(1) << id_bit);
        st       = gbia_pkg::ST_FREED;
        if (used_r != '0) begin
          used_nxt = used_r - CW'(1);
        end
      end else begin
        st = gbia_pkg::ST_IGNORED;
      end
    end
  end

  // request capture and word address
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r <= in_data.operation;
      id_r <= in_data.id;
    end
    if (cmd.find) begin
      if (op_r == gbia_pkg::OP_FREE) begin
        addr_r <= id_word;
        hit_r  <= 1'b0;
      end else if (any_elig) begin
        addr_r <= first_w;
        hit_r  <= 1'b1;
      end else begin
        addr_r <= cap_word;
        hit_r  <= 1'b0;
      end
    end
    if (cmd.commit) begin
      out_r.result_id <= gbia_pkg::ID_W'(rid);
      out_r.status    <= st;
      out_r.used_now  <= gbia_pkg::CNT_W'(used_nxt);
    end
  end

  // bitmap store, registered read
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_data_r <= mem[addr_r];
      rd_vld_r  <= word_vld_r[addr_r];
    end
    if (cmd.commit && wr) begin
      mem[addr_r] <= word_nxt;
    end
  end

  // capacity, count, word flags and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cap_r   <= gbia_pkg::MAX_CAP_RESET;
      cap_r       <= round_cap(gbia_pkg::INIT_CAP_RESET);
      used_r      <= '0;
      word_vld_r  <= '0;
      word_full_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == gbia_pkg::CFG_INIT_CAP) begin
        cap_r       <= round_cap(cfg_data);
        used_r      <= '0;
        word_vld_r  <= '0;
        word_full_r <= '0;
      end else begin
        max_cap_r <= cfg_data;
      end
    end else if (cmd.commit) begin
      cap_r  <= cap_nxt;
      used_r <= used_nxt;
      if (wr) begin
        word_vld_r[addr_r]  <= 1'b1;
        word_full_r[addr_r] <= &word_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_data     = out_r;
  assign out_valid    = out_valid_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

@@ src/growable_bitmap_id_allocator.sv @@
// Growable bitmap id allocator. Each request passes through capture, a first-free-word
// search over a per-word full flag vector, a registered read of one bitmap word, and the
// read-modify-write that also loads the output register, in that order. The next
// request is taken once that write is done, so a new request is not taken while one is
// still open. A finished result waits in the output register. The next request is still
// taken, and it stalls only at its write until that register empties. Writing
// initial_capacity clears the store through the per-word valid flags and must happen
// while no request is open.
// Depends on gbia_pkg, gbia_stream_if, gbia_ctrl and gbia_datapath.

module growable_bitmap_id_allocator #(
  parameter int MAX_IDS   = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gbia_stream_if.sink                     in_req,
  gbia_stream_if.source                   out_rsp,
  input  logic                            cfg_we,
  input  logic [gbia_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbia_pkg::CFG_W-1:0]      cfg_data
);

  gbia_pkg::ctl_cmd_t cmd;
  gbia_pkg::ctl_sts_t sts;
  gbia_pkg::req_t     req;
  gbia_pkg::rsp_t     rsp;

  assign req          = in_req.data;
  assign out_rsp.data = rsp;

  // sequencing
  gbia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // store and counters
  gbia_datapath #(
    .MAX_IDS   (MAX_IDS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (req),
    .out_data  (rsp),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
